>>> hdl/sprq_pkg.sv
package sprq_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_LEVELS  = 4;
  localparam int DEF_LEVEL_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;

  // Fixed field widths of the channels
  localparam int FUNC_W   = 1;
  localparam int PRIO_W   = 2;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 2;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Pointer/count update command from the sequencer to the level bookkeeping
  typedef struct packed {
    logic enq;   // append at the tail of the enqueue level
    logic deq;   // pop the head of the selected level
  } lvl_cmd_t;

  // Level status seen by the sequencer
  typedef struct packed {
    logic enq_full;  // enqueue level is full or does not exist
    logic any_ready; // at least one level holds an id
  } lvl_stat_t;

endpackage

>>> hdl/sprq_store.sv
module sprq_store #(
  parameter int DEPTH  = sprq_pkg::DEF_NUM_LEVELS * sprq_pkg::DEF_LEVEL_DEPTH,
  parameter int WIDTH  = sprq_pkg::DEF_ID_BITS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sprq_levels.sv
module sprq_levels #(
  parameter int NUM_LEVELS  = sprq_pkg::DEF_NUM_LEVELS,
  parameter int LEVEL_DEPTH = sprq_pkg::DEF_LEVEL_DEPTH,
  parameter int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
  parameter int ADDR_W      = $clog2(NUM_LEVELS * LEVEL_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sprq_pkg::lvl_cmd_t   cmd,
  input  logic [LVL_W-1:0]     enq_lvl,
  output sprq_pkg::lvl_stat_t  stat,
  output logic [LVL_W-1:0]     deq_lvl,
  output logic [ADDR_W-1:0]    enq_addr,
  output logic [ADDR_W-1:0]    deq_addr
);

  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LEVEL_DEPTH);

  logic [PTR_W-1:0] head_r [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r  [NUM_LEVELS];

  logic             enq_in_range;
  logic [LVL_W-1:0] enq_idx;
  logic [LVL_W-1:0] sel_lvl;
  logic             any_ready;

  assign enq_in_range = 32'(enq_lvl) < NUM_LEVELS;
  assign enq_idx      = enq_in_range ? enq_lvl : '0;

  // Pick the most urgent non-empty level; level 0 wins
  always_comb begin
    sel_lvl   = '0;
    any_ready = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        sel_lvl   = LVL_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  assign stat.enq_full  = !enq_in_range || (cnt_r[enq_idx] == CNT_FULL);
  assign stat.any_ready = any_ready;
  assign deq_lvl        = sel_lvl;

  assign enq_addr = ADDR_W'(32'(enq_idx) * LEVEL_DEPTH) + ADDR_W'(tail_r[enq_idx]);
  assign deq_addr = ADDR_W'(32'(sel_lvl) * LEVEL_DEPTH) + ADDR_W'(head_r[sel_lvl]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.enq) begin
      tail_r[enq_idx] <= (tail_r[enq_idx] == PTR_LAST) ? '0 : tail_r[enq_idx] + 1'b1;
      cnt_r[enq_idx]  <= cnt_r[enq_idx] + 1'b1;
    end else if (cmd.deq) begin
      head_r[sel_lvl] <= (head_r[sel_lvl] == PTR_LAST) ? '0 : head_r[sel_lvl] + 1'b1;
      cnt_r[sel_lvl]  <= cnt_r[sel_lvl] - 1'b1;
    end
  end

  a_no_enq_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq |-> !stat.enq_full)
    else $error("append issued to a full or missing level");

  a_no_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq |-> stat.any_ready)
    else $error("pop issued with every level empty");

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_chk
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r[g] <= CNT_FULL)
      else $error("level count above depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r[g] == '0 || cnt_r[g] == CNT_FULL) |-> head_r[g] == tail_r[g])
      else $error("head and tail disagree with level count");
  end

endmodule

>>> hdl/strict_priority_ready_queue_unit.sv
// Channel  Handshake             Payload                                   Direction
// in_      in_valid / in_ready   in_func, in_prio, in_thread_id            into block
// out_     out_valid / out_ready out_status, out_thread_id, out_prio       out of block
//
// Sequence: an accepted beat goes to the execute step, which registers an enqueue result; a
//   dequeue goes on to the data step (single-port entry memory read), which registers its
//   result, and the next beat is taken during that data step.
// Reset: rst_n low clears pointers, level counts and the sequencer; memory is not cleared.
// Stalls: a waiting result holds the output register; the next beat is still taken and
//   its execute step holds until the register frees.
module strict_priority_ready_queue_unit #(
  parameter int NUM_LEVELS  = sprq_pkg::DEF_NUM_LEVELS,
  parameter int LEVEL_DEPTH = sprq_pkg::DEF_LEVEL_DEPTH,
  parameter int ID_BITS     = sprq_pkg::DEF_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sprq_pkg::FUNC_W-1:0]   in_func,
  input  logic [sprq_pkg::PRIO_W-1:0]   in_prio,
  input  logic [sprq_pkg::TID_W-1:0]    in_thread_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sprq_pkg::STATUS_W-1:0] out_status,
  output logic [sprq_pkg::TID_W-1:0]    out_thread_id,
  output logic [sprq_pkg::PRIO_W-1:0]   out_prio
);

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,   // wait for a beat
    S_EXEC,   // look at level state, issue memory access, update pointers
    S_RDATA   // memory read data arrives; take the next beat
  } state_t;

  state_t state_r;

  // Held request
  logic [sprq_pkg::FUNC_W-1:0] func_r;
  logic [sprq_pkg::PRIO_W-1:0] prio_r;
  logic [sprq_pkg::TID_W-1:0]  tid_r;
  logic [LVL_W-1:0]            rd_lvl_r;

  // Output register
  logic                          out_valid_r;
  logic [sprq_pkg::STATUS_W-1:0] out_status_r;
  logic [sprq_pkg::TID_W-1:0]    out_tid_r;
  logic [sprq_pkg::PRIO_W-1:0]   out_prio_r;

  sprq_pkg::lvl_cmd_t  cmd;
  sprq_pkg::lvl_stat_t stat;
  logic [LVL_W-1:0]    enq_lvl;
  logic [LVL_W-1:0]    deq_lvl;
  logic [ADDR_W-1:0]   enq_addr;
  logic [ADDR_W-1:0]   deq_addr;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic                mem_re;
  logic [ID_BITS-1:0]  mem_wdata;
  logic [ID_BITS-1:0]  mem_rdata;
  logic [31:0]         prio_ext;
  logic [31:0]         rdata_ext;
  logic                prio_ok;
  logic                enq_drop;
  logic                out_free;
  logic                in_fire;
  logic                exec_go;
  logic                is_enq;

  assign in_ready = (state_r == S_IDLE) || (state_r == S_RDATA);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign exec_go  = (state_r == S_EXEC) && out_free;
  assign is_enq   = (func_r == sprq_pkg::FUNC_ENQ);

  // Levels from NUM_LEVELS up have no FIFO: drop like a full level
  assign prio_ext  = 32'(prio_r);
  assign prio_ok   = prio_ext < NUM_LEVELS;
  assign enq_lvl   = prio_ext[LVL_W-1:0];
  assign enq_drop  = !prio_ok || stat.enq_full;
  assign mem_wdata = ID_BITS'(tid_r);
  assign rdata_ext = 32'(mem_rdata);

  always_comb begin
    cmd.enq = exec_go && is_enq && !enq_drop;
    cmd.deq = exec_go && !is_enq && stat.any_ready;
  end

  assign mem_we   = cmd.enq;
  assign mem_re   = cmd.deq;
  assign mem_addr = cmd.deq ? deq_addr : enq_addr;

  sprq_levels #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .LVL_W       (LVL_W),
    .ADDR_W      (ADDR_W)
  ) u_levels (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .enq_lvl  (enq_lvl),
    .stat     (stat),
    .deq_lvl  (deq_lvl),
    .enq_addr (enq_addr),
    .deq_addr (deq_addr)
  );

  sprq_store #(
    .DEPTH  (DEPTH),
    .WIDTH  (ID_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Sequencer with the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once the consumer takes it
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            if (is_enq) begin
              out_valid_r  <= 1'b1;
              out_status_r <= enq_drop ? sprq_pkg::ST_FULL : sprq_pkg::ST_OK;
              out_tid_r    <= '0;
              out_prio_r   <= '0;
              state_r      <= S_IDLE;
            end else if (stat.any_ready) begin
              // hold the level until the entry arrives from memory
              rd_lvl_r <= deq_lvl;
              state_r  <= S_RDATA;
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= sprq_pkg::ST_EMPTY;
              out_tid_r    <= '0;
              out_prio_r   <= '0;
              state_r      <= S_IDLE;
            end
          end
        end
        S_RDATA: begin
          out_valid_r  <= 1'b1;
          out_status_r <= sprq_pkg::ST_OK;
          out_tid_r    <= rdata_ext[sprq_pkg::TID_W-1:0];
          out_prio_r   <= sprq_pkg::PRIO_W'(32'(rd_lvl_r));
          state_r      <= in_fire ? S_EXEC : S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      prio_r <= in_prio;
      tid_r  <= in_thread_id;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_thread_id = out_tid_r;
  assign out_prio      = out_prio_r;

  a_read_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (state_r == S_RDATA))
    else $error("memory read not followed by data phase");

  a_rdata_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDATA) |-> !out_valid_r)
    else $error("read data would overwrite a pending result");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("write and read on the single memory port together");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_RDATA))
    else $error("result raised outside execute or data phase");

endmodule
